/* rtl/dftb_pkg.sv */
`default_nettype none

package dftb_pkg;

  // Default sizing, handed down through the top-level parameters
  localparam int unsigned POINTS_DEF      = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned POS_BITS = 8;
  localparam int unsigned OUT_BITS = 41;
  localparam int unsigned TW_BITS  = 16;
  localparam int unsigned TW_MAX   = 32767;

  // Result stream packing: bin_real, bin_imag, out_position, zero pad to bytes
  localparam int unsigned OUT_DW       = ((2 * OUT_BITS + POS_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_BITS = OUT_DW - 2 * OUT_BITS - POS_BITS;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE_MODE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_OUTPUT = 1'd1;

  // Input transaction kinds (tuser)
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_e;

  // Control that travels alongside each issued sample through the MAC
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

/* rtl/dft_bin_engine_top.sv */
// Direct DFT, one bin per query transaction.
// Input stream (s_axis): tuser is the kind. A load transaction writes one complex
// sample into the sample store and gives no result. A query transaction names an
// output position; the block walks all POINTS samples through one shared complex
// multiply-accumulate, one sample per cycle, and returns the full unscaled sum with
// the position on the output stream (m_axis). A load or query whose position is
// POINTS or above is taken and dropped.
// The sum passes the sample-store and twiddle reads and the MAC stages into the
// output register; tready stays low from the query until its result is loaded there,
// so a new query is taken only once the last one is through.
// Configuration (cfg_we_i / cfg_idx_i / cfg_data_i): register 0 selects the inverse
// transform, register 1 the fftshift ordering; write them only while idle.
// Reset clears both registers and starts a clearing pass that zeroes the sample
// store entry by entry, during which no transaction is taken.
// A finished result sits in an output register; while it waits, new loads and a
// new query are still taken, and a second result waits in the sequencer until
// the receiver takes the first.
`default_nettype none

module dft_bin_engine_top #(
  parameter int unsigned  POINTS      = dftb_pkg::POINTS_DEF,
  parameter int unsigned  SAMPLE_BITS = dftb_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned AW          = (POINTS > 1) ? $clog2(POINTS) : 1,
  localparam int unsigned IN_DW       = ((dftb_pkg::POS_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [IN_DW-1:0]                       s_axis_tdata,  // position, sample_real, sample_imag
  input  logic                                   s_axis_tuser,  // kind
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [dftb_pkg::OUT_DW-1:0]            m_axis_tdata,  // bin_real, bin_imag, out_position
  input  logic                                   cfg_we_i,
  input  logic [dftb_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [dftb_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);
  import dftb_pkg::*;

  // Input field unpacking
  logic [POS_BITS-1:0]    in_pos;
  logic [SAMPLE_BITS-1:0] in_re, in_im;

  assign in_pos = s_axis_tdata[POS_BITS-1:0];
  assign in_re  = s_axis_tdata[POS_BITS +: SAMPLE_BITS];
  assign in_im  = s_axis_tdata[POS_BITS + SAMPLE_BITS +: SAMPLE_BITS];

  // Configuration registers
  logic inverse_q, shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q <= 1'b0;
      shift_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INVERSE_MODE: inverse_q <= cfg_data_i[0];
        REG_SHIFT_OUTPUT: shift_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  logic                    mem_we, mem_clear, out_load, out_free, mac_done;
  logic [AW-1:0]           mem_waddr, mem_raddr, tw_idx;
  logic [POS_BITS-1:0]     seq_pos;
  mac_ctl_t                mac_ctl;

  dftb_seq #(
    .POINTS (POINTS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_kind_i      (s_axis_tuser),
    .in_pos_i       (in_pos),
    .shift_output_i (shift_q),
    .out_free_i     (out_free),
    .mac_done_i     (mac_done),
    .mem_we_o       (mem_we),
    .mem_clear_o    (mem_clear),
    .mem_waddr_o    (mem_waddr),
    .mem_raddr_o    (mem_raddr),
    .tw_idx_o       (tw_idx),
    .mac_ctl_o      (mac_ctl),
    .out_load_o     (out_load),
    .out_pos_o      (seq_pos)
  );

  // Sample store
  logic [2*SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

  assign mem_wdata = mem_clear ? '0 : {in_im, in_re};

  dftb_sample_mem #(
    .POINTS      (POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Twiddle ROM
  logic signed [TW_BITS-1:0] tw_cos, tw_sin;

  dftb_twiddle_rom #(
    .POINTS (POINTS)
  ) u_rom (
    .clk_i     (clk_i),
    .idx_i     (tw_idx),
    .inverse_i (inverse_q),
    .cos_o     (tw_cos),
    .sin_o     (tw_sin)
  );

  // Shared complex multiply-accumulate
  logic signed [OUT_BITS-1:0] acc_re, acc_im;

  dftb_cmac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cmac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .x_re_i   (mem_rdata[SAMPLE_BITS-1:0]),
    .x_im_i   (mem_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .c_i      (tw_cos),
    .s_i      (tw_sin),
    .done_o   (mac_done),
    .acc_re_o (acc_re),
    .acc_im_o (acc_im)
  );

  // Output register
  logic                out_valid_q;
  logic [OUT_BITS-1:0] out_re_q, out_im_q;
  logic [POS_BITS-1:0] out_pos_q;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_re_q  <= acc_re;
      out_im_q  <= acc_im;
      out_pos_q <= seq_pos;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, out_pos_q, out_im_q, out_re_q};

  // Checks
  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded over an untaken result");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_clear |-> !s_axis_tready)
    else $error("transaction taken during clearing pass");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> !s_axis_tready)
    else $error("MAC finished while sequencer idle");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(out_load))
    else $error("output valid without a result load");

endmodule

`default_nettype wire

/* rtl/dftb_sample_mem.sv */
`default_nettype none

module dftb_sample_mem #(
  parameter int unsigned  POINTS      = dftb_pkg::POINTS_DEF,
  parameter int unsigned  SAMPLE_BITS = dftb_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned AW          = (POINTS > 1) ? $clog2(POINTS) : 1,
  localparam int unsigned DW          = 2 * SAMPLE_BITS
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,   // real part low, imaginary part high
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [POINTS];
  logic [DW-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/dftb_twiddle_rom.sv */
`default_nettype none

module dftb_twiddle_rom #(
  parameter int unsigned  POINTS = dftb_pkg::POINTS_DEF,
  localparam int unsigned AW     = (POINTS > 1) ? $clog2(POINTS) : 1
) (
  input  logic                                clk_i,
  input  logic [AW-1:0]                       idx_i,
  input  logic                                inverse_i,
  output logic signed [dftb_pkg::TW_BITS-1:0] cos_o,
  output logic signed [dftb_pkg::TW_BITS-1:0] sin_o
);
  import dftb_pkg::*;

  localparam real PI   = 3.14159265358979323846;
  localparam real STEP = 2.0 * PI / real'(POINTS);
  localparam real SNAP = 1.0 / 1073741824.0;

  typedef logic [2*TW_BITS-1:0] rom_t [POINTS];

  // round(32767 * v), half away from zero; values within 2^-30 of 0, 1/2 or 1
  // are snapped onto them so that exact angles give exact codes
  function automatic logic [TW_BITS-1:0] scale_round(real v);
    real u;
    int  r;
    u = (v < 0.0) ? -v : v;
    if (u < SNAP) begin
      u = 0.0;
    end else if (u + SNAP > 1.0) begin
      u = 1.0;
    end else if ((u + SNAP > 0.5) && (u < 0.5 + SNAP)) begin
      u = 0.5;
    end
    r = $rtoi(u * real'(TW_MAX) + 0.5);
    if (v < 0.0) begin
      r = -r;
    end
    return TW_BITS'(r);
  endfunction

  // Entry m holds {sin, cos} of 2*pi*m/POINTS
  function automatic rom_t build_rom();
    rom_t rom;
    real  ang;
    for (int m = 0; m < POINTS; m++) begin
      ang    = STEP * real'(m);
      rom[m] = {scale_round($sin(ang)), scale_round($cos(ang))};
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [2*TW_BITS-1:0]      word;
  logic signed [TW_BITS-1:0] cos_q;
  logic signed [TW_BITS-1:0] sin_q;

  assign word = ROM[idx_i];

  // Registered read; sine negated for the forward transform
  always_ff @(posedge clk_i) begin
    cos_q <= word[TW_BITS-1:0];
    sin_q <= inverse_i ? word[2*TW_BITS-1:TW_BITS] : -word[2*TW_BITS-1:TW_BITS];
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

`default_nettype wire

/* rtl/dftb_cmac.sv */
`default_nettype none

module dftb_cmac #(
  parameter int unsigned SAMPLE_BITS = dftb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dftb_pkg::mac_ctl_t                   ctl_i,    // issue cycle
  input  logic signed [SAMPLE_BITS-1:0]        x_re_i,   // the cycle after issue
  input  logic signed [SAMPLE_BITS-1:0]        x_im_i,
  input  logic signed [dftb_pkg::TW_BITS-1:0]  c_i,
  input  logic signed [dftb_pkg::TW_BITS-1:0]  s_i,
  output logic                                 done_o,
  output logic signed [dftb_pkg::OUT_BITS-1:0] acc_re_o,
  output logic signed [dftb_pkg::OUT_BITS-1:0] acc_im_o
);
  import dftb_pkg::*;

  localparam int unsigned PW = SAMPLE_BITS + TW_BITS;
  localparam int unsigned SW = PW + 1;

  mac_ctl_t ctl_s1_q, ctl_s2_q, ctl_s3_q;
  logic     done_q;

  logic signed [PW-1:0]       p_rc_q, p_is_q, p_rs_q, p_ic_q;
  logic signed [SW-1:0]       sum_re_q, sum_im_q;
  logic signed [OUT_BITS-1:0] acc_re_q, acc_im_q;

  // Control pipeline, aligned with the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s1_q <= '0;
      ctl_s2_q <= '0;
      ctl_s3_q <= '0;
      done_q   <= 1'b0;
    end else begin
      ctl_s1_q <= ctl_i;
      ctl_s2_q <= ctl_s1_q;
      ctl_s3_q <= ctl_s2_q;
      done_q   <= ctl_s3_q.valid && ctl_s3_q.last;
    end
  end

  // Stage 2: four partial products
  always_ff @(posedge clk_i) begin
    p_rc_q <= x_re_i * c_i;
    p_is_q <= x_im_i * s_i;
    p_rs_q <= x_re_i * s_i;
    p_ic_q <= x_im_i * c_i;
  end

  // Stage 3: complex product
  always_ff @(posedge clk_i) begin
    sum_re_q <= SW'(p_rc_q) - SW'(p_is_q);
    sum_im_q <= SW'(p_rs_q) + SW'(p_ic_q);
  end

  // Stage 4: accumulate, restarting on the first sample of a query
  always_ff @(posedge clk_i) begin
    if (ctl_s3_q.valid) begin
      if (ctl_s3_q.first) begin
        acc_re_q <= OUT_BITS'(sum_re_q);
        acc_im_q <= OUT_BITS'(sum_im_q);
      end else begin
        acc_re_q <= acc_re_q + OUT_BITS'(sum_re_q);
        acc_im_q <= acc_im_q + OUT_BITS'(sum_im_q);
      end
    end
  end

  assign done_o   = done_q;
  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;

endmodule

`default_nettype wire

/* rtl/dftb_seq.sv */
`default_nettype none

module dftb_seq #(
  parameter int unsigned  POINTS = dftb_pkg::POINTS_DEF,
  localparam int unsigned AW     = (POINTS > 1) ? $clog2(POINTS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_kind_i,
  input  logic [dftb_pkg::POS_BITS-1:0]   in_pos_i,
  input  logic                            shift_output_i,
  input  logic                            out_free_i,
  input  logic                            mac_done_i,
  output logic                            mem_we_o,
  output logic                            mem_clear_o,
  output logic [AW-1:0]                   mem_waddr_o,
  output logic [AW-1:0]                   mem_raddr_o,
  output logic [AW-1:0]                   tw_idx_o,
  output dftb_pkg::mac_ctl_t              mac_ctl_o,
  output logic                            out_load_o,
  output logic [dftb_pkg::POS_BITS-1:0]   out_pos_o
);
  import dftb_pkg::*;

  localparam int unsigned IW = AW + 1;
  localparam int unsigned EW = (IW > POS_BITS) ? IW : POS_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(POINTS - 1);
  localparam logic [IW-1:0] POINTS_W = IW'(POINTS);
  localparam logic [IW-1:0] HALF_W   = IW'(POINTS / 2);

  seq_state_e          state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       tw_q, tw_d;
  logic [AW-1:0]       bin_q, bin_d;
  logic [POS_BITS-1:0] pos_q, pos_d;

  logic [EW-1:0] pos_ext;
  logic          in_range;
  logic          cnt_last;
  logic [AW-1:0] pos_addr;
  logic [IW-1:0] bin_sum;
  logic [AW-1:0] bin_sel;
  logic [IW-1:0] tw_sum;
  logic [AW-1:0] tw_next;

  assign pos_ext  = EW'(in_pos_i);
  assign in_range = pos_ext < EW'(POINTS);
  assign pos_addr = pos_ext[AW-1:0];
  assign cnt_last = (cnt_q == LAST_IDX);

  // fftshift: bin = (p + POINTS/2) mod POINTS
  assign bin_sum = IW'(pos_addr) + HALF_W;
  always_comb begin
    if (!shift_output_i) begin
      bin_sel = pos_addr;
    end else if (bin_sum >= POINTS_W) begin
      bin_sel = AW'(bin_sum - POINTS_W);
    end else begin
      bin_sel = bin_sum[AW-1:0];
    end
  end

  // Twiddle index steps by the bin, modulo POINTS
  assign tw_sum  = IW'(tw_q) + IW'(bin_q);
  assign tw_next = (tw_sum >= POINTS_W) ? AW'(tw_sum - POINTS_W) : tw_sum[AW-1:0];

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tw_q  <= tw_d;
    bin_q <= bin_d;
    pos_q <= pos_d;
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tw_d        = tw_q;
    bin_d       = bin_q;
    pos_d       = pos_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_clear_o = 1'b0;
    mem_waddr_o = pos_addr;
    mac_ctl_o   = '0;
    out_load_o  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        // zero the sample store, one entry a cycle
        mem_we_o    = 1'b1;
        mem_clear_o = 1'b1;
        mem_waddr_o = cnt_q;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_range) begin
          if (in_kind_i == KIND_LOAD) begin
            mem_we_o = 1'b1;
          end else begin
            pos_d   = in_pos_i;
            bin_d   = bin_sel;
            cnt_d   = '0;
            tw_d    = '0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // issue one sample and twiddle per cycle
        mac_ctl_o.valid = 1'b1;
        mac_ctl_o.first = (cnt_q == '0);
        mac_ctl_o.last  = cnt_last;
        cnt_d           = cnt_q + 1'b1;
        tw_d            = tw_next;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done_i) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_raddr_o = cnt_q;
  assign tw_idx_o    = tw_q;
  assign out_pos_o   = pos_q;

endmodule

`default_nettype wire
